>>> rtl/triangle_pixel_coverage_shade_macros.svh
// assertion macros for the triangle pixel coverage and shade block
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef TRIANGLE_PIXEL_COVERAGE_SHADE_MACROS_SVH
`define TRIANGLE_PIXEL_COVERAGE_SHADE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPCS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpcs assertion failed");

// next-cycle implication, disabled during reset
`define TPCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpcs assertion failed");

`endif

>>> rtl/tpcs_pkg.sv
// shared widths, codes and pipeline payload types of the coverage and shade block
// no dependencies
package tpcs_pkg;

    localparam int CW    = 13;          // coordinate bits
    localparam int DW    = CW + 1;      // coordinate differences
    localparam int PW    = 2 * DW;      // edge partial products
    localparam int EW    = PW + 1;      // determinants
    localparam int SW    = EW + 2;      // third barycentric term before range check
    localparam int UW    = PW;          // covered edge values, unsigned
    localparam int ZW    = 16;          // depth Q2.14
    localparam int RWW   = 16;          // reciprocal w Q4.12
    localparam int CLW   = 8;           // color channel
    localparam int NCH   = 3;           // color channels
    localparam int NV    = 3;           // triangle vertices
    localparam int KW    = UW + RWW;    // perspective weight
    localparam int KSW   = KW + 2;      // weight sum
    localparam int MW    = KW + CLW;    // weighted color term
    localparam int NUMW  = KSW + CLW;   // weighted color sum
    localparam int ZPW   = UW + 1 + ZW; // weighted depth term
    localparam int NW    = ZPW + 2;     // weighted depth sum
    localparam int DSH   = 14;          // depth one in Q2.14
    localparam int DLW   = UW + DSH + 1;
    localparam int XW    = 11;          // echoed pixel position
    localparam int FW    = 12;          // frame size registers
    localparam int QW    = CLW;         // quotient bits

    localparam logic [FW-1:0]  FRAME_MAX   = 12'd2048;
    localparam logic [FW-1:0]  FRAME_W_RST = 12'd640;
    localparam logic [FW-1:0]  FRAME_H_RST = 12'd480;
    localparam logic [CLW-1:0] ALPHA_FULL  = 8'd255;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    localparam logic CFG_FRAME_W = 1'b0;
    localparam logic CFG_FRAME_H = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RWW-1:0]       rw;
        logic [NCH-1:0][CLW-1:0] c;
    } t_vtx;

    typedef t_vtx [NV-1:0] t_tri;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic [RWW-1:0]       rw;
        logic [NCH-1:0][CLW-1:0] c;
    } t_attr;

    typedef t_attr [NV-1:0] t_attrs;

    // after coverage: edge weights of a pixel, wr set if it is covered
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic [XW-1:0]      x;
        logic [XW-1:0]      y;
        logic [UW-1:0]      det;
        logic [NV-1:0][UW-1:0] e;
        t_attrs             attr;
    } t_edge;

    // divider input: numerators per channel over one weight sum
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic [XW-1:0]      x;
        logic [XW-1:0]      y;
        logic [KSW-1:0]     ksum;
        logic [NCH-1:0][NUMW-1:0] num;
    } t_div;

    // finished pixel transaction
    typedef struct packed {
        logic               valid;
        logic               wr;
        logic [XW-1:0]      x;
        logic [XW-1:0]      y;
        logic [NCH-1:0][CLW-1:0] col;
    } t_pix;

endpackage

>>> rtl/triangle_pixel_coverage_shade.sv
// Triangle coverage and shade unit. Load transactions (op 0) store one of three vertices;
// shade transactions (op 1) test a pixel against the stored triangle and its frame-clamped
// bounding box (inclusive upper edges), the edge determinants and the depth range [-1,1],
// and return a perspective-correct color with alpha 255. Every transaction, load or shade,
// yields exactly one result. One transaction is taken per clock unless o_in_stall is high;
// each result passes through 17 register stages: five setup stages, three weighting
// stages, an eight-stage restoring divider that forms one color bit per stage, and the
// output register. A one-entry skid buffer behind the output register lets the pipeline keep
// taking input after the output stalls, until it fills. A shade sees every load accepted
// before it. The user must write frame size only when idle; the block does not enforce it.
`include "triangle_pixel_coverage_shade_macros.svh"

module triangle_pixel_coverage_shade (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [tpcs_pkg::FW-1:0]        i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [1:0]                     i_vertex_slot,
    input  logic signed [tpcs_pkg::CW-1:0] i_coord_x,
    input  logic signed [tpcs_pkg::CW-1:0] i_coord_y,
    input  logic signed [tpcs_pkg::ZW-1:0] i_vertex_depth,
    input  logic [tpcs_pkg::RWW-1:0]       i_recip_w,
    input  logic [tpcs_pkg::CLW-1:0]       i_red_in,
    input  logic [tpcs_pkg::CLW-1:0]       i_green_in,
    input  logic [tpcs_pkg::CLW-1:0]       i_blue_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_write_pixel,
    output logic [tpcs_pkg::XW-1:0]        o_out_x,
    output logic [tpcs_pkg::XW-1:0]        o_out_y,
    output logic [tpcs_pkg::CLW-1:0]       o_red_out,
    output logic [tpcs_pkg::CLW-1:0]       o_green_out,
    output logic [tpcs_pkg::CLW-1:0]       o_blue_out,
    output logic [tpcs_pkg::CLW-1:0]       o_alpha_out
);

    logic [tpcs_pkg::FW-1:0]         r_frame_w, r_frame_h;
    tpcs_pkg::t_vtx                  r_vtx [tpcs_pkg::NV];
    tpcs_pkg::t_tri                  w_tri;
    logic signed [tpcs_pkg::DW-1:0]  w_lim_x, w_lim_y;
    logic                            w_adv, w_accept, w_take;
    tpcs_pkg::t_edge                 w_edge;
    tpcs_pkg::t_div                  w_div;
    tpcs_pkg::t_pix                  w_pix;
    tpcs_pkg::t_pix                  r_out, r_skid;
    logic                            w_out_blank;

    assign w_adv      = !r_skid.valid;
    assign o_in_stall = r_skid.valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_take     = !r_out.valid || !i_out_stall;

    // upper box edge: frame size clamped to the maximum, minus one
    assign w_lim_x = tpcs_pkg::DW'((r_frame_w > tpcs_pkg::FRAME_MAX)
        ? tpcs_pkg::FRAME_MAX : r_frame_w) - tpcs_pkg::DW'(1);
    assign w_lim_y = tpcs_pkg::DW'((r_frame_h > tpcs_pkg::FRAME_MAX)
        ? tpcs_pkg::FRAME_MAX : r_frame_h) - tpcs_pkg::DW'(1);

    always_comb begin
        for (int i = 0; i < tpcs_pkg::NV; i++) begin
            w_tri[i] = r_vtx[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= tpcs_pkg::FRAME_W_RST;
            r_frame_h <= tpcs_pkg::FRAME_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpcs_pkg::CFG_FRAME_W: r_frame_w <= i_cfg_data;
                tpcs_pkg::CFG_FRAME_H: r_frame_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpcs_pkg::NV; i++) begin
                r_vtx[i] <= '0;
            end
        end else if (w_accept && i_op == tpcs_pkg::OP_LOAD
                     && i_vertex_slot < 2'(tpcs_pkg::NV)) begin
            r_vtx[i_vertex_slot].x  <= i_coord_x;
            r_vtx[i_vertex_slot].y  <= i_coord_y;
            r_vtx[i_vertex_slot].z  <= i_vertex_depth;
            r_vtx[i_vertex_slot].rw <= i_recip_w;
            r_vtx[i_vertex_slot].c  <= {i_blue_in, i_green_in, i_red_in};
        end
    end

    tpcs_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_accept),
        .i_op    (i_op),
        .i_px    (i_coord_x),
        .i_py    (i_coord_y),
        .i_tri   (w_tri),
        .i_lim_x (w_lim_x),
        .i_lim_y (w_lim_y),
        .o_edge  (w_edge)
    );

    tpcs_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_edge  (w_edge),
        .o_div   (w_div)
    );

    tpcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_div   (w_div),
        .o_pix   (w_pix)
    );

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (r_skid.valid) begin
            if (w_take) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end
        end else if (w_take) begin
            r_out <= w_pix;
        end else if (w_pix.valid) begin
            r_skid <= w_pix;
        end
    end

    assign o_out_valid   = r_out.valid;
    assign o_write_pixel = r_out.wr;
    assign o_out_x       = r_out.x;
    assign o_out_y       = r_out.y;
    assign o_red_out     = r_out.col[0];
    assign o_green_out   = r_out.col[1];
    assign o_blue_out    = r_out.col[2];
    assign o_alpha_out   = tpcs_pkg::ALPHA_FULL;

    assign w_out_blank = (o_red_out == '0) && (o_green_out == '0) && (o_blue_out == '0)
        && (o_out_x == '0);

    `TPCS_ASSERT_NOW(a_skid_behind_out, r_skid.valid, r_out.valid)
    `TPCS_ASSERT_NOW(a_reject_black, o_out_valid && !o_write_pixel, w_out_blank)
    `TPCS_ASSERT_NEXT(a_skid_drains, r_skid.valid && !i_out_stall, !r_skid.valid && o_out_valid)
    `TPCS_ASSERT_NEXT(a_skid_fill, !r_skid.valid && !w_take && w_pix.valid, r_skid.valid)

endmodule

>>> rtl/tpcs_setup.sv
// bounding box, edge determinants and coverage test, five register stages
// depends on tpcs_pkg
module tpcs_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_op,
    input  logic signed [tpcs_pkg::CW-1:0] i_px,
    input  logic signed [tpcs_pkg::CW-1:0] i_py,
    input  tpcs_pkg::t_tri                i_tri,
    input  logic signed [tpcs_pkg::DW-1:0] i_lim_x,
    input  logic signed [tpcs_pkg::DW-1:0] i_lim_y,
    output tpcs_pkg::t_edge               o_edge
);

    // stage 1: captured transaction with triangle snapshot
    logic                            r1_v;
    logic                            r1_op;
    logic signed [tpcs_pkg::CW-1:0]  r1_px, r1_py;
    tpcs_pkg::t_tri                  r1_tri;

    logic signed [tpcs_pkg::DW-1:0]  n_dx1, n_dy1, n_dx2, n_dy2, n_qx, n_qy;
    logic                            n_inbox;
    tpcs_pkg::t_attrs                n_attr;

    // stage 2: products
    logic                            r2_v, r2_op, r2_inbox;
    logic [tpcs_pkg::XW-1:0]         r2_x, r2_y;
    logic signed [tpcs_pkg::PW-1:0]  r2_a, r2_b, r2_c, r2_d, r2_e, r2_f;
    tpcs_pkg::t_attrs                r2_attr;

    // stage 3: raw determinants
    logic                            r3_v, r3_op, r3_inbox;
    logic [tpcs_pkg::XW-1:0]         r3_x, r3_y;
    logic signed [tpcs_pkg::EW-1:0]  r3_det, r3_e1, r3_e2;
    tpcs_pkg::t_attrs                r3_attr;

    // stage 4: sign normalized
    logic                            r4_v, r4_op, r4_inbox;
    logic [tpcs_pkg::XW-1:0]         r4_x, r4_y;
    logic signed [tpcs_pkg::EW-1:0]  r4_det, r4_e1, r4_e2;
    tpcs_pkg::t_attrs                r4_attr;

    logic                            n_neg;
    logic signed [tpcs_pkg::SW-1:0]  n_e0;
    logic                            n_cover;

    // stage 5
    tpcs_pkg::t_edge                 r5;

    always_comb begin
        n_dx1 = tpcs_pkg::DW'(r1_tri[1].x) - tpcs_pkg::DW'(r1_tri[0].x);
        n_dy1 = tpcs_pkg::DW'(r1_tri[1].y) - tpcs_pkg::DW'(r1_tri[0].y);
        n_dx2 = tpcs_pkg::DW'(r1_tri[2].x) - tpcs_pkg::DW'(r1_tri[0].x);
        n_dy2 = tpcs_pkg::DW'(r1_tri[2].y) - tpcs_pkg::DW'(r1_tri[0].y);
        n_qx  = tpcs_pkg::DW'(r1_px) - tpcs_pkg::DW'(r1_tri[0].x);
        n_qy  = tpcs_pkg::DW'(r1_py) - tpcs_pkg::DW'(r1_tri[0].y);
        // clamped box: at or above the origin and within the frame
        n_inbox = (r1_px >= 0) && (r1_py >= 0)
            && (tpcs_pkg::DW'(r1_px) <= i_lim_x) && (tpcs_pkg::DW'(r1_py) <= i_lim_y);
        // at or above the smallest vertex, at or below the largest one
        n_inbox = n_inbox
            && (r1_px >= r1_tri[0].x || r1_px >= r1_tri[1].x || r1_px >= r1_tri[2].x)
            && (r1_py >= r1_tri[0].y || r1_py >= r1_tri[1].y || r1_py >= r1_tri[2].y)
            && (r1_px <= r1_tri[0].x || r1_px <= r1_tri[1].x || r1_px <= r1_tri[2].x)
            && (r1_py <= r1_tri[0].y || r1_py <= r1_tri[1].y || r1_py <= r1_tri[2].y);
        for (int i = 0; i < tpcs_pkg::NV; i++) begin
            n_attr[i].z  = r1_tri[i].z;
            n_attr[i].rw = r1_tri[i].rw;
            n_attr[i].c  = r1_tri[i].c;
        end
    end

    always_comb begin
        n_neg   = r4_det < 0;
        n_e0    = tpcs_pkg::SW'(r4_det) - tpcs_pkg::SW'(r4_e1) - tpcs_pkg::SW'(r4_e2);
        n_cover = r4_inbox && (r4_det != 0) && (n_e0 >= 0) && (r4_e1 >= 0) && (r4_e2 >= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r5.valid <= 1'b0;
        end else if (i_adv) begin
            r1_v     <= i_valid;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r5.valid <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_op    <= i_op;
            r1_px    <= i_px;
            r1_py    <= i_py;
            r1_tri   <= i_tri;

            r2_op    <= r1_op;
            r2_inbox <= n_inbox;
            r2_x     <= r1_px[tpcs_pkg::XW-1:0];
            r2_y     <= r1_py[tpcs_pkg::XW-1:0];
            r2_a     <= n_dx1 * n_dy2;
            r2_b     <= n_dx2 * n_dy1;
            r2_c     <= n_qx * n_dy2;
            r2_d     <= n_dx2 * n_qy;
            r2_e     <= n_dx1 * n_qy;
            r2_f     <= n_qx * n_dy1;
            r2_attr  <= n_attr;

            r3_op    <= r2_op;
            r3_inbox <= r2_inbox;
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_det   <= tpcs_pkg::EW'(r2_a) - tpcs_pkg::EW'(r2_b);
            r3_e1    <= tpcs_pkg::EW'(r2_c) - tpcs_pkg::EW'(r2_d);
            r3_e2    <= tpcs_pkg::EW'(r2_e) - tpcs_pkg::EW'(r2_f);
            r3_attr  <= r2_attr;

            r4_op    <= r3_op;
            r4_inbox <= r3_inbox;
            r4_x     <= r3_x;
            r4_y     <= r3_y;
            r4_det   <= (r3_det < 0) ? -r3_det : r3_det;
            r4_e1    <= (r3_det < 0) ? -r3_e1  : r3_e1;
            r4_e2    <= (r3_det < 0) ? -r3_e2  : r3_e2;
            r4_attr  <= r3_attr;

            r5.wr    <= (r4_op == tpcs_pkg::OP_SHADE) && n_cover && !n_neg;
            r5.x     <= r4_x;
            r5.y     <= r4_y;
            r5.det   <= r4_det[tpcs_pkg::UW-1:0];
            r5.e[0]  <= n_e0[tpcs_pkg::UW-1:0];
            r5.e[1]  <= r4_e1[tpcs_pkg::UW-1:0];
            r5.e[2]  <= r4_e2[tpcs_pkg::UW-1:0];
            r5.attr  <= r4_attr;
        end
    end

    assign o_edge = r5;

endmodule

>>> rtl/tpcs_weight.sv
// perspective weights, depth range test and color numerators, three stages
// depends on tpcs_pkg
module tpcs_weight (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tpcs_pkg::t_edge  i_edge,
    output tpcs_pkg::t_div   o_div
);

    logic                             r6_v, r6_wr;
    logic [tpcs_pkg::XW-1:0]          r6_x, r6_y;
    logic [tpcs_pkg::UW-1:0]          r6_det;
    logic [tpcs_pkg::KW-1:0]          r6_k  [tpcs_pkg::NV];
    logic signed [tpcs_pkg::ZPW-1:0]  r6_zp [tpcs_pkg::NV];
    logic [tpcs_pkg::NCH-1:0][tpcs_pkg::CLW-1:0] r6_c [tpcs_pkg::NV];

    logic                             r7_v, r7_wr;
    logic [tpcs_pkg::XW-1:0]          r7_x, r7_y;
    logic [tpcs_pkg::UW-1:0]          r7_det;
    logic [tpcs_pkg::KSW-1:0]         r7_ksum;
    logic signed [tpcs_pkg::NW-1:0]   r7_n;
    logic [tpcs_pkg::MW-1:0]          r7_m [tpcs_pkg::NV][tpcs_pkg::NCH];

    logic signed [tpcs_pkg::UW:0]     n_es [tpcs_pkg::NV];
    logic [tpcs_pkg::DLW-1:0]         n_lim;
    logic signed [tpcs_pkg::NW-1:0]   n_lim_s;
    logic                             n_depth_ok;

    tpcs_pkg::t_div                   r8;

    always_comb begin
        for (int i = 0; i < tpcs_pkg::NV; i++) begin
            n_es[i] = {1'b0, i_edge.e[i]};
        end
        // depth one times det in the numerator's scale
        n_lim      = {1'b0, r7_det, {tpcs_pkg::DSH{1'b0}}};
        n_lim_s    = $signed(tpcs_pkg::NW'(n_lim));
        n_depth_ok = (r7_n >= -n_lim_s) && (r7_n <= n_lim_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v     <= 1'b0;
            r7_v     <= 1'b0;
            r8.valid <= 1'b0;
        end else if (i_adv) begin
            r6_v     <= i_edge.valid;
            r7_v     <= r6_v;
            r8.valid <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_wr  <= i_edge.wr;
            r6_x   <= i_edge.x;
            r6_y   <= i_edge.y;
            r6_det <= i_edge.det;
            for (int i = 0; i < tpcs_pkg::NV; i++) begin
                r6_k[i]  <= i_edge.e[i] * i_edge.attr[i].rw;
                r6_zp[i] <= n_es[i] * i_edge.attr[i].z;
                r6_c[i]  <= i_edge.attr[i].c;
            end

            r7_wr   <= r6_wr;
            r7_x    <= r6_x;
            r7_y    <= r6_y;
            r7_det  <= r6_det;
            r7_ksum <= tpcs_pkg::KSW'(r6_k[0]) + tpcs_pkg::KSW'(r6_k[1])
                + tpcs_pkg::KSW'(r6_k[2]);
            r7_n    <= tpcs_pkg::NW'(r6_zp[0]) + tpcs_pkg::NW'(r6_zp[1])
                + tpcs_pkg::NW'(r6_zp[2]);
            for (int i = 0; i < tpcs_pkg::NV; i++) begin
                for (int ch = 0; ch < tpcs_pkg::NCH; ch++) begin
                    r7_m[i][ch] <= r6_k[i] * r6_c[i][ch];
                end
            end

            r8.wr   <= r7_wr && n_depth_ok;
            r8.x    <= r7_x;
            r8.y    <= r7_y;
            r8.ksum <= r7_ksum;
            for (int ch = 0; ch < tpcs_pkg::NCH; ch++) begin
                r8.num[ch] <= tpcs_pkg::NUMW'(r7_m[0][ch]) + tpcs_pkg::NUMW'(r7_m[1][ch])
                    + tpcs_pkg::NUMW'(r7_m[2][ch]);
            end
        end
    end

    assign o_div = r8;

endmodule

>>> rtl/tpcs_div.sv
// pipelined restoring divider, one quotient bit per stage for each color channel
// depends on tpcs_pkg
module tpcs_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  tpcs_pkg::t_div  i_div,
    output tpcs_pkg::t_pix  o_pix
);

    typedef struct packed {
        logic                     valid;
        logic                     wr;
        logic [tpcs_pkg::XW-1:0]  x;
        logic [tpcs_pkg::XW-1:0]  y;
        logic [tpcs_pkg::KSW-1:0] ksum;
        logic [tpcs_pkg::NCH-1:0][tpcs_pkg::NUMW-1:0] rem;
        logic [tpcs_pkg::NCH-1:0][tpcs_pkg::QW-1:0]   q;
    } t_dst;

    t_dst s_d [tpcs_pkg::QW+1];

    always_comb begin
        s_d[0].valid = i_div.valid;
        s_d[0].wr    = i_div.wr;
        s_d[0].x     = i_div.x;
        s_d[0].y     = i_div.y;
        s_d[0].ksum  = i_div.ksum;
        s_d[0].rem   = i_div.num;
        s_d[0].q     = '0;
    end

    for (genvar j = 0; j < tpcs_pkg::QW; j++) begin : g_step
        t_dst r_d;
        t_dst n_d;
        logic [tpcs_pkg::NUMW-1:0] n_sh;
        logic [tpcs_pkg::NUMW:0]   n_trial [tpcs_pkg::NCH];

        always_comb begin
            n_d  = s_d[j];
            n_sh = tpcs_pkg::NUMW'(s_d[j].ksum) << (tpcs_pkg::QW - 1 - j);
            for (int ch = 0; ch < tpcs_pkg::NCH; ch++) begin
                n_trial[ch] = {1'b0, s_d[j].rem[ch]} - {1'b0, n_sh};
                n_d.q[ch]   = {s_d[j].q[ch][tpcs_pkg::QW-2:0], !n_trial[ch][tpcs_pkg::NUMW]};
                if (!n_trial[ch][tpcs_pkg::NUMW]) begin
                    n_d.rem[ch] = n_trial[ch][tpcs_pkg::NUMW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d.valid <= 1'b0;
            end else if (i_adv) begin
                r_d.valid <= n_d.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_d.wr   <= n_d.wr;
                r_d.x    <= n_d.x;
                r_d.y    <= n_d.y;
                r_d.ksum <= n_d.ksum;
                r_d.rem  <= n_d.rem;
                r_d.q    <= n_d.q;
            end
        end

        assign s_d[j+1] = r_d;
    end

    // zero weight sum gives black, rejected pixels give all zero
    always_comb begin
        o_pix.valid = s_d[tpcs_pkg::QW].valid;
        o_pix.wr    = s_d[tpcs_pkg::QW].wr;
        o_pix.x     = s_d[tpcs_pkg::QW].wr ? s_d[tpcs_pkg::QW].x : '0;
        o_pix.y     = s_d[tpcs_pkg::QW].wr ? s_d[tpcs_pkg::QW].y : '0;
        for (int ch = 0; ch < tpcs_pkg::NCH; ch++) begin
            o_pix.col[ch] = (s_d[tpcs_pkg::QW].wr && s_d[tpcs_pkg::QW].ksum != '0)
                ? s_d[tpcs_pkg::QW].q[ch] : '0;
        end
    end

endmodule
